// ===== hdl/segment_surface_height_query_unit_assert.svh =====
// Assertion macros used by the checker file
`ifndef SEGMENT_SURFACE_HEIGHT_QUERY_UNIT_ASSERT_SVH
`define SEGMENT_SURFACE_HEIGHT_QUERY_UNIT_ASSERT_SVH

// Check a property on the rising clock edge, suspended while reset is low
`define SSHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset
`define SSHQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sshq_pkg.sv =====
// ----------------------------------------------------------------------------
// sshq_pkg
// Types and constants of the segment surface height query unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sshq_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_DIVLOAD,
    ST_DIV,
    ST_ACC,
    ST_RESP
  } state_e;

  // Restoring division: 40-bit dividend, one quotient bit per cycle
  localparam int unsigned DivSteps = 40;
  localparam int unsigned DivCntW  = 6;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned SurfW    = 24;

  typedef struct packed {
    logic take;     // latch the accepted item
    logic exec;     // perform clear/append, arm the scan
    logic rd;       // read the table entry at the scan index
    logic mul;      // form the slope product
    logic divload;  // load the divider
    logic divstep;  // one division step
    logic acc;      // fold the height into the best candidate
    logic next;     // advance the scan index
    logic load_out; // capture the result
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic last;
    logic match;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/sshq_datapath.sv =====
// ----------------------------------------------------------------------------
// sshq_datapath
// Segment table, interpolation multiplier, serial divider and best-height
// tracking for the segment surface height query unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sshq_datapath
  import sshq_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  output logic [OutDataW-1:0]      out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  op_e                op_q;
  logic [InDataW-1:0] in_q;
  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    idx_q;
  logic               status_q;
  logic [63:0]        mem [MAX_SEGMENTS];
  logic [63:0]        rd_q;
  logic signed [33:0] prod_q;
  logic [15:0]        den_q;
  logic signed [15:0] ly_q;
  logic               neg_q;
  logic [39:0]        dvd_q;
  logic [15:0]        rem_q;
  logic [DivCntW-1:0] dcnt_q;
  logic signed [25:0] best_q;
  logic               found_q;
  logic [OutDataW-1:0] out_q;

  logic signed [15:0] lx, ly, rx, ry, qx, qy;
  logic signed [16:0] dy, dxq;
  logic [16:0]        trial;
  logic               fits;
  logic [33:0]        mag;
  logic signed [25:0] qs, y, qy8;
  logic               better, full, hit;

  assign lx = $signed(rd_q[15:0]);
  assign ly = $signed(rd_q[31:16]);
  assign rx = $signed(rd_q[47:32]);
  assign ry = $signed(rd_q[63:48]);
  assign qx = $signed(in_q[79:64]);
  assign qy = $signed(in_q[95:80]);

  assign dy  = {ry[15], ry} - {ly[15], ly};
  assign dxq = {qx[15], qx} - {lx[15], lx};
  assign mag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);

  assign trial = {rem_q, dvd_q[39]};
  assign fits  = trial >= {1'b0, den_q};

  assign qs  = neg_q ? -$signed({1'b0, dvd_q[24:0]}) : $signed({1'b0, dvd_q[24:0]});
  assign y   = $signed({{2{ly_q[15]}}, ly_q, 8'h00}) + qs;
  assign qy8 = $signed({{2{qy[15]}}, qy, 8'h00});
  assign better = (y >= qy8) && (!found_q || (y < best_q));

  assign full = count_q == CntW'(MAX_SEGMENTS);
  assign hit  = (op_q == OP_QUERY) && found_q;

  assign sts_o.op       = op_q;
  assign sts_o.empty    = count_q == '0;
  assign sts_o.last     = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign sts_o.match    = (lx != rx) && (qx >= lx) && (qx <= rx);
  assign sts_o.div_last = dcnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      if (op_q == OP_CLEAR) begin
        count_q <= '0;
      end else if (op_q == OP_APPEND && !full) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // Table write on append, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && op_q == OP_APPEND && !full) begin
      mem[count_q[IdxW-1:0]] <= in_q[63:0];
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q <= op_e'(op_i);
      in_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      idx_q    <= '0;
      found_q  <= 1'b0;
      best_q   <= '0;
      status_q <= (op_q == OP_APPEND) && full;
    end
    if (cmd_i.next) begin
      idx_q <= idx_q + IdxW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= dy * dxq;
      den_q  <= 16'(rx - lx);
      ly_q   <= ly;
    end
    if (cmd_i.divload) begin
      neg_q  <= prod_q[33];
      dvd_q  <= {mag[31:0], 8'h00};
      rem_q  <= '0;
      dcnt_q <= DivCntW'(DivSteps - 1);
    end
    if (cmd_i.divstep) begin
      rem_q  <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      dvd_q  <= {dvd_q[38:0], fits};
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
    if (cmd_i.acc && better) begin
      best_q  <= y;
      found_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q <= {6'd0, status_q, hit ? best_q[SurfW-1:0] : SurfW'(0), hit};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/sshq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sshq_ctrl
// Sequencer of the segment surface height query unit: input and output
// handshakes and the per-segment scan.
// ----------------------------------------------------------------------------
`default_nettype none

module sshq_ctrl
  import sshq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.exec = 1'b1;
        state_d = (sts_i.op == OP_QUERY && !sts_i.empty) ? ST_READ : ST_RESP;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.match) begin
          state_d = ST_DIVLOAD;
        end else if (sts_i.last) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_DIVLOAD: begin
        cmd_o.divload = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.divstep = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.last) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/segment_surface_height_query_unit.sv =====
// ----------------------------------------------------------------------------
// segment_surface_height_query_unit
// Segment table with nearest-surface-below queries.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser carries the operation (clear, append, query),
// tdata the segment end points and the probe point. Output channel m_axis:
// one transaction per input transaction with hit, surface_y (Q16.8) and
// status. Items are handled one at a time; s_axis_tready is high only while
// the sequencer is idle.
// Clear, append and unused codes, and a query on an empty table, go from the
// decode state straight to the response state. A query reads and evaluates
// each of the N stored segments in turn; each segment spanning the probe x
// runs a 40-step restoring division in the shared serial divider. A new
// input transaction is taken only after the previous one has been loaded
// into the output register.
// The output register lets the next input transaction in while a result
// waits; a stalled receiver holds the result and blocks the next one from
// completing. Reset empties the table (count to zero) and drops any pending
// result; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_surface_height_query_unit
  import sshq_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // left_x, left_y, right_x, right_y, query_x, query_y
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // operation
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // hit, surface_y, status, zero fill
  output logic [OutDataW-1:0]      m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  sshq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sshq_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/sshq_checker.sv =====
// ----------------------------------------------------------------------------
// sshq_checker
// Port-level checks of the segment surface height query unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_surface_height_query_unit_assert.svh"

module sshq_checker
  import sshq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  `SSHQ_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `SSHQ_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
  `SSHQ_ASSERT(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[24:1] == '0, "surface nonzero without hit")
  `SSHQ_ASSERT(a_hit_status, clk_i, rst_ni, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[25]), "hit and refusal together")
  `SSHQ_ASSERT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while busy")

endmodule

bind segment_surface_height_query_unit sshq_checker u_sshq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_segment_surface_height_query_unit.sv =====
// ----------------------------------------------------------------------------
// tb_segment_surface_height_query_unit
// Self-checking bench: random segment tables and probe queries against a
// behavioral height predictor, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class height_scoreboard;
  logic [63:0] seg_tbl [64];
  int          seg_cnt;
  logic [31:0] pending_q [$];
  int          errors;

  function new();
    seg_cnt = 0;
    errors  = 0;
  endfunction

  // Work out the expected result of one accepted transaction
  function void note_item(sshq_pkg::op_e op, logic [95:0] d);
    logic              hit;
    logic signed [23:0] surf;
    logic              status;
    logic [31:0]       exp_v;
    longint            qx, qy8, lx, ly, rx, ry, y, best;
    hit = 1'b0;
    surf = '0;
    status = 1'b0;
    best = 0;
    case (op)
      sshq_pkg::OP_CLEAR: begin
        seg_cnt = 0;
      end
      sshq_pkg::OP_APPEND: begin
        if (seg_cnt >= 64) begin
          status = 1'b1;
        end else begin
          seg_tbl[seg_cnt] = d[63:0];
          seg_cnt++;
        end
      end
      sshq_pkg::OP_QUERY: begin
        qx  = $signed(d[79:64]);
        qy8 = longint'($signed(d[95:80])) * 256;
        for (int i = 0; i < seg_cnt; i++) begin
          lx = $signed(seg_tbl[i][15:0]);
          ly = $signed(seg_tbl[i][31:16]);
          rx = $signed(seg_tbl[i][47:32]);
          ry = $signed(seg_tbl[i][63:48]);
          if (lx == rx || qx < lx || qx > rx) continue;
          y = ly * 256 + ((ry - ly) * (qx - lx) * 256) / (rx - lx);
          if (y >= qy8 && (!hit || y < best)) begin
            best = y;
            hit = 1'b1;
          end
        end
        if (hit) surf = best[23:0];
      end
      default: ;
    endcase
    exp_v = {6'd0, status, surf, hit};
    pending_q = {pending_q, exp_v};
  endfunction

  function void check_result(logic [31:0] act);
    logic [31:0] exp_v;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, act);
      errors++;
      return;
    end
    exp_v = pending_q.pop_front();
    if (act[0] !== exp_v[0]) begin
      $display("%0t: hit exp %b act %b", $time, exp_v[0], act[0]);
      errors++;
    end
    if (act[24:1] !== exp_v[24:1]) begin
      $display("%0t: surface_y exp %h act %h", $time, exp_v[24:1], act[24:1]);
      errors++;
    end
    if (act[25] !== exp_v[25]) begin
      $display("%0t: status exp %b act %b", $time, exp_v[25], act[25]);
      errors++;
    end
    if (act[31:26] !== exp_v[31:26]) begin
      $display("%0t: fill exp %h act %h", $time, exp_v[31:26], act[31:26]);
      errors++;
    end
  endfunction
endclass

module tb_segment_surface_height_query_unit;
  import sshq_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  height_scoreboard heights;
  bit   hold_off_req;
  int   gap_left;

  segment_surface_height_query_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("segment_surface_height_query_unit verification failed");
    $finish;
  end

  // Receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int          pat;
    logic        got;
    logic [31:0] got_data;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      // sample mid-cycle: the handshake seen here completes at the next edge
      @(negedge clk_i);
      got      = m_axis_tvalid && m_axis_tready;
      got_data = m_axis_tdata;
      @(posedge clk_i);
      if (got) heights.check_result(got_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        pat = $urandom_range(0, 15);
        m_axis_tready <= (pat < 3) ? 1'b0 : 1'b1;
      end
    end
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5, 6: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one transaction, holding tvalid until accepted; bursty gaps
  task automatic send_item(op_e op, logic [95:0] d);
    logic rdy;
    if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    if (gap_left > 0) gap_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    forever begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
      if (rdy) break;
    end
    heights.note_item(op, d);
  endtask

  task automatic send_segment(logic [15:0] lx, logic [15:0] ly,
                              logic [15:0] rx, logic [15:0] ry);
    send_item(OP_APPEND, {32'd0, ry, rx, ly, lx});
  endtask

  task automatic send_query(logic [15:0] qx, logic [15:0] qy);
    send_item(OP_QUERY, {qy, qx, 64'd0});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (heights.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] a, b;
    heights       = new();
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CLEAR;
    rst_ni        = 1'b0;
    gap_left      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty query, extremes, vertical, reversed, tie, unused code, clear, overfull table
    send_query(16'h0000, 16'h8000);
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_segment(16'd5, 16'd0, 16'd5, 16'd100);
    send_segment(16'd50, 16'd0, 16'd10, 16'd10);
    send_segment(16'd0, 16'd10, 16'd20, 16'd10);
    send_segment(16'd0, 16'd10, 16'd20, 16'd10);
    send_query(16'h8000, 16'h8000);
    send_query(16'h7fff, 16'h8000);
    send_query(16'h0000, 16'h7fff);
    send_query(16'd5, 16'd0);
    send_query(16'd7, 16'hffff);
    send_query(16'd30, 16'd0);
    send_item(OP_NONE, {96{1'b1}});
    send_item(OP_CLEAR, {96{1'b1}});
    send_query(16'd5, 16'd0);
    for (int i = 0; i < 65; i++) begin
      send_segment(16'(i), 16'(-i), 16'(i + 3), 16'(i));
    end
    send_query(16'd10, 16'h8000);
    drain();

    // Long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    gap_left = 20;
    send_item(OP_CLEAR, '0);
    for (int i = 0; i < 10; i++) begin
      send_segment(16'($urandom_range(0, 40) - 40), 16'($urandom_range(0, 60)),
                   16'($urandom_range(0, 40)), 16'($urandom_range(0, 60)));
    end
    send_query(16'd0, 16'd0);
    drain();

    // Random: mostly well-formed and mostly small tables then queries, with noise
    for (int n = 0; n < 1100; ) begin
      int sz;
      if ($urandom_range(0, 5) == 0) begin
        send_item(op_e'($urandom_range(0, 3)), {$urandom, $urandom, $urandom});
        n++;
        continue;
      end
      send_item(OP_CLEAR, {$urandom, $urandom, $urandom});
      n++;
      sz = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
      for (int k = 0; k < sz; k++) begin
        a = pick_coord();
        b = pick_coord();
        if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) begin
          send_segment(b, pick_coord(), a, pick_coord());
        end else begin
          send_segment(a, pick_coord(), b, pick_coord());
        end
        n++;
      end
      for (int k = $urandom_range(1, 6); k > 0; k--) begin
        if ($urandom_range(0, 1)) send_query(16'($urandom_range(0, 200) - 100),
                                              16'($urandom_range(0, 400) - 200));
        else send_query(pick_coord(), pick_coord());
        n++;
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (heights.errors == 0) begin
      $display("segment_surface_height_query_unit verification clean");
    end else begin
      $display("segment_surface_height_query_unit verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sshq_pkg.sv
hdl/sshq_datapath.sv
hdl/sshq_ctrl.sv
hdl/segment_surface_height_query_unit.sv
hdl/sshq_checker.sv
bench/tb_segment_surface_height_query_unit.sv
